>>> hdl/slnt_pkg.sv
// types and codes shared by the sorted leaf node table
package slnt_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_SPLIT    = 3'd1,
    ACT_LOCATE   = 3'd2,
    ACT_READ     = 3'd3,
    ACT_SET_NEXT = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic        [30:0] page;
    logic        [30:0] slot;
  } entry_t;

  typedef struct packed {
    logic        [2:0]  action;
    logic signed [31:0] key;
    logic        [30:0] rec_page;
    logic        [30:0] rec_slot;
    logic        [6:0]  entry_index;
    logic        [30:0] new_next_page;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [6:0]  found_index;
    logic signed [31:0] out_key;
    logic        [30:0] out_page;
    logic        [30:0] out_slot;
    logic        [6:0]  key_count;
    logic        [30:0] next_page;
    logic               last;
  } out_item_t;

endpackage

>>> hdl/slnt_chan_if.sv
// valid/ready channels for requests and results
interface slnt_in_if;
  logic                valid;
  logic                ready;
  slnt_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slnt_out_if;
  logic                valid;
  logic                ready;
  slnt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sorted_leaf_node_table.sv
// sorted leaf node table: one b+tree leaf kept in a single entry memory
// insert: walks down from the top, shifting each larger key up one slot, then writes the new entry
// split: the insert without its reply, then each entry of the upper half is read and sent out in turn
// locate scans up from slot 0; read entry, set next and clear give one reply; one item at a time
// reset (synchronous, rst_n low) and clear zero the count and the next pointer; slots
// at or above the count read as zero, so the memory itself needs no clearing pass
module sorted_leaf_node_table #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  slnt_in_if.sink    in_ch,
  slnt_out_if.source out_ch
);
  import slnt_pkg::*;

  localparam int DEPTH = CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(CAPACITY + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_INS_ZERO, S_SPL_RD, S_SPL_OUT, S_LOC, S_RDE, S_RESP
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   top_r, top_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [30:0]     next_r, next_nxt;
  logic            split_r, split_nxt;
  in_item_t        item_r, item_nxt;
  status_t         res_status_r, res_status_nxt;
  logic [6:0]      res_found_r, res_found_nxt;
  entry_t          res_entry_r, res_entry_nxt;
  out_item_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  slnt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    logic          out_free;
    logic [CW-1:0] n1;
    entry_t        new_e;
    logic          ins_done;

    state_nxt      = state_r;
    count_nxt      = count_r;
    top_nxt        = top_r;
    idx_nxt        = idx_r;
    next_nxt       = next_r;
    split_nxt      = split_r;
    item_nxt       = item_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_entry_nxt  = res_entry_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    ins_done       = 1'b0;

    out_free   = !out_valid_r || out_ch.ready;
    n1         = top_r + CW'(1);
    new_e.key  = item_r.key;
    new_e.page = item_r.rec_page;
    new_e.slot = item_r.rec_slot;
    wr_data    = new_e;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt       = in_ch.data;
          res_status_nxt = ST_OK;
          res_found_nxt  = '0;
          res_entry_nxt  = '0;
          top_nxt        = count_r;
          split_nxt      = (in_ch.data.action == ACT_SPLIT);
          state_nxt      = S_RESP;
          case (in_ch.data.action)
            ACT_INSERT, ACT_SPLIT: begin
              if (in_ch.data.action == ACT_INSERT && 32'(count_r) >= 32'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                state_nxt = S_INS_ZERO;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(count_r - CW'(1));
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_INS;
              end
            end
            ACT_LOCATE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_LOC;
              end
            end
            ACT_READ: begin
              if (in_ch.data.entry_index == 7'd0 ||
                  32'(in_ch.data.entry_index) > 32'(CAPACITY)) begin
                res_status_nxt = ST_BAD_INDEX;
              end else if (8'(in_ch.data.entry_index) <= 8'(count_r)) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_ch.data.entry_index - 7'd1);
                state_nxt = S_RDE;
              end
            end
            ACT_SET_NEXT: begin
              next_nxt = in_ch.data.new_next_page;
            end
            ACT_CLEAR: begin
              count_nxt = '0;
              next_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // walk down from the top, moving larger keys up one slot
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        if ($signed(item_r.key) < $signed(rd_data.key)) begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INS_ZERO;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end
        end else begin
          ins_done = 1'b1;
        end
      end

      S_INS_ZERO: begin
        wr_en    = 1'b1;
        wr_addr  = '0;
        ins_done = 1'b1;
      end

      S_SPL_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_SPL_OUT;
      end

      S_SPL_OUT: begin
        if (out_free) begin
          out_nxt.status      = ST_OK;
          out_nxt.found_index = '0;
          out_nxt.out_key     = rd_data.key;
          out_nxt.out_page    = rd_data.page;
          out_nxt.out_slot    = rd_data.slot;
          out_nxt.key_count   = 7'(count_r);
          out_nxt.next_page   = next_r;
          out_nxt.last        = (idx_r == AW'(top_r));
          out_valid_nxt       = 1'b1;
          if (idx_r == AW'(top_r)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_SPL_RD;
          end
        end
      end

      // scan up for the first key at or above the search key
      S_LOC: begin
        if ($signed(rd_data.key) >= $signed(item_r.key)) begin
          res_found_nxt = 7'(idx_r) + 7'd1;
          state_nxt     = S_RESP;
        end else if (CW'(idx_r) + CW'(1) == count_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_RDE: begin
        res_entry_nxt = rd_data;
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_nxt.status      = res_status_r;
          out_nxt.found_index = res_found_r;
          out_nxt.out_key     = res_entry_r.key;
          out_nxt.out_page    = res_entry_r.page;
          out_nxt.out_slot    = res_entry_r.slot;
          out_nxt.key_count   = 7'(count_r);
          out_nxt.next_page   = next_r;
          out_nxt.last        = 1'b1;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // new entry written: settle the count, then either report or move the upper half
    if (ins_done) begin
      if (split_r) begin
        count_nxt = CW'(n1 >> 1);
        idx_nxt   = AW'(n1 >> 1);
        state_nxt = S_SPL_RD;
      end else begin
        count_nxt = n1;
        state_nxt = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r        <= top_nxt;
    idx_r        <= idx_nxt;
    split_r      <= split_nxt;
    item_r       <= item_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_entry_r  <= res_entry_nxt;
    out_r        <= out_nxt;
  end

endmodule

>>> hdl/slnt_store.sv
// entry store: one write port, one read port with registered read data
module slnt_store #(
  parameter int DEPTH = 65,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output slnt_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  slnt_pkg::entry_t wr_data
);
  import slnt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
